@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the grid strip index generator.
// No dependencies; define SYNTH to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// label: antecedent implies consequent, sampled on clk, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// label: expression never holds, sampled on clk, off during reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

@@ rtl/gsig_pkg.sv @@
// Package for the grid strip index generator: codes, field widths and the
// structs passed between its modules. No dependencies.
package gsig_pkg;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W     = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd21;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

    // section / phase codes
    localparam logic [1:0] PH_STRIP = 2'd0;
    localparam logic [1:0] PH_ULINE = 2'd1;
    localparam logic [1:0] PH_VLINE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [IDX_W-1:0] RESTART_MARK = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] phase;
        logic       pair_half;
        logic       restart_pending;
    } gsig_flags_t;

    typedef struct packed {
        logic       is_restart;
        logic [1:0] section;
        logic       section_last;
        logic       list_last;
    } gsig_res_t;

endpackage

@@ rtl/gsig_cfg.sv @@
// Configuration registers (grid_cols, grid_rows) with clamped side outputs.
// Depends on gsig_pkg.
module gsig_cfg #(
    parameter int MAX_SIDE = 256,
    parameter int SW       = 9
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gsig_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsig_pkg::CFG_W-1:0]       cfg_data,
    output logic [SW-1:0]                    cols_clamped,
    output logic [SW-1:0]                    rows_clamped
);
    import gsig_pkg::*;

    logic [CFG_W-1:0] grid_cols_reg;
    logic [CFG_W-1:0] grid_rows_reg;

    function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [31:0] ext;
        logic [31:0] res;
        ext = 32'(v);
        if (ext < 32'd2)
            res = 32'd2;
        else if (ext > 32'(MAX_SIDE))
            res = 32'(MAX_SIDE);
        else
            res = ext;
        return res[SW-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= CFG_RESET;
            grid_rows_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
            endcase
        end
    end

    assign cols_clamped = clamp_side(grid_cols_reg);
    assign rows_clamped = clamp_side(grid_rows_reg);

endmodule

@@ rtl/gsig_step.sv @@
// Next-state and result logic for one request: counters, strip/line walk,
// one n*a+b index multiply. Purely combinational. Depends on gsig_pkg.
module gsig_step #(
    parameter int SW = 9
) (
    input  logic                   start_over,
    input  gsig_pkg::gsig_flags_t  flags,
    input  logic [SW-1:0]          outer_count,
    input  logic [SW-1:0]          inner_count,
    input  logic [SW-1:0]          lat_cols,
    input  logic [SW-1:0]          lat_rows,
    input  logic [SW-1:0]          cols_clamped,
    input  logic [SW-1:0]          rows_clamped,
    output logic                   emit,
    output gsig_pkg::gsig_flags_t  flags_next,
    output logic [SW-1:0]          outer_next,
    output logic [SW-1:0]          inner_next,
    output logic [SW-1:0]          cols_next,
    output logic [SW-1:0]          rows_next,
    output logic [gsig_pkg::IDX_W-1:0] vertex_next,
    output gsig_pkg::gsig_res_t    res_next
);
    import gsig_pkg::*;

    localparam int PW = 2 * SW;
    localparam int IW = PW + 1;

    gsig_flags_t      fl;
    logic [SW-1:0]    outer_c;
    logic [SW-1:0]    inner_c;
    logic [SW-1:0]    n;
    logic [SW-1:0]    m;
    logic [SW-1:0]    inner_inc;
    logic [SW-1:0]    outer_inc;
    logic [SW-1:0]    mul_a;
    logic [SW-1:0]    mul_b;
    logic [PW-1:0]    prod;
    logic [IW-1:0]    sum;

    // a start replaces the state before the step is taken
    always_comb
    begin
        if (start_over)
        begin
            fl.phase           = PH_STRIP;
            fl.pair_half       = 1'b0;
            fl.restart_pending = 1'b0;
            outer_c            = SW'(1);
            inner_c            = '0;
            n                  = cols_clamped;
            m                  = rows_clamped;
        end
        else
        begin
            fl      = flags;
            outer_c = outer_count;
            inner_c = inner_count;
            n       = lat_cols;
            m       = lat_rows;
        end
    end

    assign emit      = start_over || (flags.phase != PH_DONE);
    assign inner_inc = inner_c + SW'(1);
    assign outer_inc = outer_c + SW'(1);
    assign cols_next = n;
    assign rows_next = m;

    always_comb
    begin
        flags_next       = fl;
        outer_next       = outer_c;
        inner_next       = inner_c;
        mul_a            = outer_c;
        mul_b            = inner_c;
        res_next.is_restart   = 1'b0;
        res_next.section      = fl.phase;
        res_next.section_last = 1'b0;
        res_next.list_last    = 1'b0;

        if (fl.restart_pending)
        begin
            res_next.is_restart        = 1'b1;
            flags_next.restart_pending = 1'b0;
        end
        else
        begin
            case (fl.phase)
                PH_STRIP:
                begin
                    // row outer_c first, then the previous row (outer_c - 1)
                    mul_a = fl.pair_half ? (outer_c - SW'(1)) : outer_c;
                    flags_next.pair_half = !fl.pair_half;
                    if (fl.pair_half)
                    begin
                        inner_next = inner_inc;
                        if (inner_inc >= n)
                        begin
                            inner_next = '0;
                            outer_next = outer_inc;
                            if (outer_inc >= m)
                            begin
                                res_next.section_last = 1'b1;
                                flags_next.phase      = PH_ULINE;
                                outer_next            = '0;
                            end
                            else
                                flags_next.restart_pending = 1'b1;
                        end
                    end
                end
                PH_ULINE:
                begin
                    inner_next = inner_inc;
                    if (inner_inc >= n)
                    begin
                        inner_next = '0;
                        outer_next = outer_inc;
                        if (outer_inc >= m)
                        begin
                            res_next.section_last = 1'b1;
                            flags_next.phase      = PH_VLINE;
                            outer_next            = '0;
                        end
                        flags_next.restart_pending = 1'b1;
                    end
                end
                PH_VLINE:
                begin
                    mul_a      = inner_c;
                    mul_b      = outer_c;
                    inner_next = inner_inc;
                    if (inner_inc >= m)
                    begin
                        inner_next = '0;
                        outer_next = outer_inc;
                        if (outer_inc >= n)
                        begin
                            res_next.section_last = 1'b1;
                            res_next.list_last    = 1'b1;
                            flags_next.phase      = PH_DONE;
                            outer_next            = '0;
                        end
                        else
                            flags_next.restart_pending = 1'b1;
                    end
                end
                default:
                begin
                    // idle: nothing moves
                end
            endcase
        end
    end

    assign prod = PW'(n) * PW'(mul_a);
    assign sum  = {1'b0, prod} + IW'(mul_b);

    assign vertex_next = res_next.is_restart ? RESTART_MARK : IDX_W'(sum);

endmodule

@@ rtl/grid_strip_index_generator_top.sv @@
// Each accepted request's item goes into the single state/result register stage.
// Throughput: one request per cycle unless a held result stalls the input.
// Requests after the list ends (or before any start) are taken and give no item.
// Reset (rst_n, async low): list idle, counters zero, grid_cols = grid_rows = 21.
// Top level of the grid strip index generator; uses gsig_pkg, gsig_cfg,
// gsig_step and assert_macros.svh.
`include "assert_macros.svh"

module grid_strip_index_generator_top #(
    parameter int MAX_SIDE = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             start_over,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [gsig_pkg::IDX_W-1:0]       vertex_index,
    output logic                             is_restart,
    output logic [1:0]                       section,
    output logic                             section_last,
    output logic                             list_last,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gsig_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsig_pkg::CFG_W-1:0]       cfg_data
);
    import gsig_pkg::*;

    // counters and latched sides must hold MAX_SIDE itself
    localparam int SW = $clog2(MAX_SIDE + 1);

    logic [SW-1:0] cols_clamped;
    logic [SW-1:0] rows_clamped;

    // walk state, updated on every accepted request
    gsig_flags_t   flags_reg;
    gsig_flags_t   flags_next;
    logic [SW-1:0] outer_reg;
    logic [SW-1:0] outer_next;
    logic [SW-1:0] inner_reg;
    logic [SW-1:0] inner_next;
    // grid size latched at start, so register writes mid-list wait for the next start
    logic [SW-1:0] lat_cols_reg;
    logic [SW-1:0] lat_cols_next;
    logic [SW-1:0] lat_rows_reg;
    logic [SW-1:0] lat_rows_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IDX_W-1:0]  vertex_reg;
    logic [IDX_W-1:0]  vertex_next;
    gsig_res_t         res_reg;
    gsig_res_t         res_next;

    logic emit;
    logic in_accept;

    gsig_cfg #(
        .MAX_SIDE (MAX_SIDE),
        .SW       (SW)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cols_clamped (cols_clamped),
        .rows_clamped (rows_clamped)
    );

    gsig_step #(
        .SW (SW)
    ) u_step (
        .start_over   (start_over),
        .flags        (flags_reg),
        .outer_count  (outer_reg),
        .inner_count  (inner_reg),
        .lat_cols     (lat_cols_reg),
        .lat_rows     (lat_rows_reg),
        .cols_clamped (cols_clamped),
        .rows_clamped (rows_clamped),
        .emit         (emit),
        .flags_next   (flags_next),
        .outer_next   (outer_next),
        .inner_next   (inner_next),
        .cols_next    (lat_cols_next),
        .rows_next    (lat_rows_next),
        .vertex_next  (vertex_next),
        .res_next     (res_next)
    );

    // A new request is taken whenever the result register is empty or is
    // being drained this cycle; only a held result stalls the input.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            out_valid_next = emit;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.phase           <= PH_DONE;
            flags_reg.pair_half       <= 1'b0;
            flags_reg.restart_pending <= 1'b0;
            outer_reg                 <= '0;
            inner_reg                 <= '0;
            lat_cols_reg              <= '0;
            lat_rows_reg              <= '0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                flags_reg    <= flags_next;
                outer_reg    <= outer_next;
                inner_reg    <= inner_next;
                lat_cols_reg <= lat_cols_next;
                lat_rows_reg <= lat_rows_next;
            end
        end
    end

    // payload only loads with a fresh item
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            vertex_reg <= vertex_next;
            res_reg    <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = vertex_reg;
    assign is_restart   = res_reg.is_restart;
    assign section      = res_reg.section;
    assign section_last = res_reg.section_last;
    assign list_last    = res_reg.list_last;

    // restart items always carry the marker value
    `ASSERT_IMPLY(a_restart_mark, clk, rst_n, out_valid && is_restart, vertex_index == RESTART_MARK)
    // end of list is the end of the v-line section
    `ASSERT_IMPLY(a_list_last, clk, rst_n, out_valid && list_last, section_last && section == PH_VLINE)
    // a marker is never queued in the middle of a strip column pair
    `ASSERT_NEVER(a_pair_pend, clk, rst_n, flags_reg.pair_half && flags_reg.restart_pending)
    // inner counter stays inside the current line
    `ASSERT_IMPLY(a_inner_bound, clk, rst_n, flags_reg.phase != PH_DONE, inner_reg < ((flags_reg.phase == PH_VLINE) ? lat_rows_reg : lat_cols_reg))
    // the input only stalls behind a held result
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid_reg)

endmodule
